>>> rtl/core/route_path_length_walker_assert.svh
// Assertion macros for the route path length walker
`ifndef ROUTE_PATH_LENGTH_WALKER_ASSERT_SVH
`define ROUTE_PATH_LENGTH_WALKER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that an expression holds at every clock edge outside reset
`define RPLW_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("rplw check failed");
// Check that a consequent holds whenever an antecedent holds
`define RPLW_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rplw check failed");
`else
`define RPLW_ASSERT(lbl, expr)
`define RPLW_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

>>> rtl/core/rplw_pkg.sv
package rplw_pkg;

   // Stream payload widths
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 48;
   localparam int STATUS_W   = 2;
   localparam int OP_W       = 2;
   localparam int COORD_W    = 16;
   localparam int REAL_W     = 32;
   localparam int LEN_W      = 33;
   localparam int PATH_W     = 41;

   // Record kinds
   typedef enum logic [OP_W-1:0] {
      OP_DRIVER = 2'd0,
      OP_LOAD   = 2'd1,
      OP_WIRE   = 2'd2
   } op_type;

   // Walk outcome
   typedef enum logic [STATUS_W-1:0] {
      STATUS_REACHED     = 2'd0,
      STATUS_INTERRUPTED = 2'd1,
      STATUS_EXHAUSTED   = 2'd2,
      STATUS_OVERFLOW    = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_LOAD  = 2'd0,
      ST_START = 2'd1,
      ST_SCAN  = 2'd2,
      ST_POST  = 2'd3
   } state_type;

   // Search probe travelling down the row of cells
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [LEN_W-1:0] len;
   } probe_type;

endpackage

>>> rtl/core/rplw_cell.sv
module rplw_cell #(
   parameter int CELL_W = 32,
   parameter int CNT_W  = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic [CELL_W-1:0]          cur_cell,
   input  logic [CELL_W-1:0]          start_prev,
   input  logic [CELL_W-1:0]          end_prev,
   input  logic [rplw_pkg::LEN_W-1:0] len_prev,
   output logic [CELL_W-1:0]          start_cell,
   output logic [CELL_W-1:0]          end_cell,
   output logic [rplw_pkg::LEN_W-1:0] wire_len,
   input  rplw_pkg::probe_type        probe_prev,
   input  logic [CNT_W-1:0]           left_prev,
   input  logic [CELL_W-1:0]          hit_end_prev,
   output rplw_pkg::probe_type        probe_next,
   output logic [CNT_W-1:0]           left_next,
   output logic [CELL_W-1:0]          hit_end_next
);
   import rplw_pkg::*;

   logic [CELL_W-1:0] start_ff, end_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              taken_ff, taken_in;
   probe_type         probe_ff, probe_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [CELL_W-1:0] hit_end_ff, hit_end_in;
   logic              hit;

   // Claim this wire if in use, untaken, starting at cur_cell and none found yet
   always_comb begin
      hit = probe_prev.valid && !probe_prev.found && (left_prev != '0) &&
            !taken_ff && (start_ff == cur_cell);
      taken_in = shift_en ? 1'b0 : (taken_ff | hit);
      probe_in.valid = probe_prev.valid;
      probe_in.found = probe_prev.found | hit;
      probe_in.len   = hit ? len_ff : probe_prev.len;
      hit_end_in     = hit ? end_ff : hit_end_prev;
      left_in        = (left_prev != '0) ? left_prev - 1'b1 : '0;
   end

   // Shift wire contents along the row on load
   always_ff @(posedge clock) begin
      if (shift_en) begin
         start_ff <= start_prev;
         end_ff   <= end_prev;
         len_ff   <= len_prev;
      end
      taken_ff   <= taken_in;
      left_ff    <= left_in;
      hit_end_ff <= hit_end_in;
   end

   // Advance the probe one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign start_cell   = start_ff;
   assign end_cell     = end_ff;
   assign wire_len     = len_ff;
   assign probe_next   = probe_ff;
   assign left_next    = left_ff;
   assign hit_end_next = hit_end_ff;

endmodule

>>> rtl/core/rplw_chain.sv
module rplw_chain #(
   parameter int MAX_WIRES = 256,
   parameter int CELL_W    = 32,
   parameter int CNT_W     = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic [CELL_W-1:0]          cur_cell,
   input  logic [CELL_W-1:0]          new_start,
   input  logic [CELL_W-1:0]          new_end,
   input  logic [rplw_pkg::LEN_W-1:0] new_len,
   input  rplw_pkg::probe_type        probe_head,
   input  logic [CNT_W-1:0]           left_head,
   output rplw_pkg::probe_type        probe_tail,
   output logic [CELL_W-1:0]          hit_end_tail
);
   import rplw_pkg::*;

   logic [CELL_W-1:0] start_c   [MAX_WIRES];
   logic [CELL_W-1:0] end_c     [MAX_WIRES];
   logic [LEN_W-1:0]  len_c     [MAX_WIRES];
   probe_type         probe_c   [MAX_WIRES];
   logic [CNT_W-1:0]  left_c    [MAX_WIRES];
   logic [CELL_W-1:0] hit_end_c [MAX_WIRES];

   // Row of cells: newest wire sits at the head, the probe runs head to tail
   for (genvar i = 0; i < MAX_WIRES; i++) begin : g_cell
      logic [CELL_W-1:0] start_prev, end_prev, hit_end_prev;
      logic [LEN_W-1:0]  len_prev;
      probe_type         probe_prev;
      logic [CNT_W-1:0]  left_prev;

      if (i == 0) begin : g_head
         assign start_prev   = new_start;
         assign end_prev     = new_end;
         assign len_prev     = new_len;
         assign probe_prev   = probe_head;
         assign left_prev    = left_head;
         assign hit_end_prev = '0;
      end else begin : g_body
         assign start_prev   = start_c[i-1];
         assign end_prev     = end_c[i-1];
         assign len_prev     = len_c[i-1];
         assign probe_prev   = probe_c[i-1];
         assign left_prev    = left_c[i-1];
         assign hit_end_prev = hit_end_c[i-1];
      end

      rplw_cell #(
         .CELL_W (CELL_W),
         .CNT_W  (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .shift_en     (shift_en),
         .cur_cell     (cur_cell),
         .start_prev   (start_prev),
         .end_prev     (end_prev),
         .len_prev     (len_prev),
         .start_cell   (start_c[i]),
         .end_cell     (end_c[i]),
         .wire_len     (len_c[i]),
         .probe_prev   (probe_prev),
         .left_prev    (left_prev),
         .hit_end_prev (hit_end_prev),
         .probe_next   (probe_c[i]),
         .left_next    (left_c[i]),
         .hit_end_next (hit_end_c[i])
      );
   end

   assign probe_tail   = probe_c[MAX_WIRES-1];
   assign hit_end_tail = hit_end_c[MAX_WIRES-1];

endmodule

>>> rtl/core/route_path_length_walker.sv
// Records are taken one beat per cycle while loading, and none while a last beat is held;
// a wire passes through the stage register into the cell row. After the last beat the walk
// runs: every step is one pass of the probe along the MAX_WIRES-cell row, and at most one
// step is taken per held wire.
// New records wait during the walk; a finished result waits in the output register.
// Synchronous active-high reset empties the net and drops any pending result.
module route_path_length_walker #(
   parameter int MAX_WIRES = 256,
   parameter int GRID_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // grid_x1, grid_y1, grid_x2, grid_y2, real_x1, real_y1, real_x2, real_y2
   input  logic [rplw_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [rplw_pkg::OP_W-1:0]       req_tuser,
   input  logic                            req_tlast,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // path_length, zero pad
   output logic [rplw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [rplw_pkg::STATUS_W-1:0]   rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);
   import rplw_pkg::*;

`include "route_path_length_walker_assert.svh"

   localparam int CELL_W = 2 * GRID_BITS;
   localparam int CNT_W  = $clog2(MAX_WIRES + 1);

   // Beat fields
   logic [OP_W-1:0]    f_op;
   logic [COORD_W-1:0] f_gx1, f_gy1, f_gx2, f_gy2;
   logic [REAL_W-1:0]  f_rx1, f_ry1, f_rx2, f_ry2;
   logic [REAL_W-1:0]  dx, dy;
   logic               req_fire;

   // Control and datapath registers
   state_type         state_ff, state_in;
   logic              stage_valid_ff, stage_valid_in;
   op_type            stage_op_ff;
   logic              stage_last_ff;
   logic [CELL_W-1:0] stage_cell1_ff, stage_cell2_ff;
   logic [REAL_W-1:0] stage_dx_ff, stage_dy_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [CELL_W-1:0] driver_ff, driver_in;
   logic [CELL_W-1:0] load_ff, load_in;
   logic [CELL_W-1:0] cur_ff, cur_in;
   logic [PATH_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [PATH_W-1:0] res_len_ff, res_len_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PATH_W-1:0] rsp_len_ff;
   status_type        rsp_status_ff;

   // Walk step evaluation
   logic              table_full;
   logic              probe_done;
   logic [PATH_W:0]   sum_wide;
   logic [PATH_W-1:0] sum_sat;
   logic [CNT_W-1:0]  left_dec;
   logic              step_reached, step_out;
   logic              start_empty;
   logic              post_fire;

   // Chain interface
   logic              shift_en, launch;
   probe_type         probe_head, probe_tail;
   logic [CELL_W-1:0] hit_end_tail;
   logic [LEN_W-1:0]  new_len;

   // Unpack the beat
   assign f_op  = req_tuser;
   assign f_gx1 = req_tdata[15:0];
   assign f_gy1 = req_tdata[31:16];
   assign f_gx2 = req_tdata[47:32];
   assign f_gy2 = req_tdata[63:48];
   assign f_rx1 = req_tdata[95:64];
   assign f_ry1 = req_tdata[127:96];
   assign f_rx2 = req_tdata[159:128];
   assign f_ry2 = req_tdata[191:160];
   assign req_fire = req_tvalid && req_tready;

   // Absolute coordinate differences of the wire ends
   always_comb begin
      dx = ($signed(f_rx1) >= $signed(f_rx2)) ? f_rx1 - f_rx2 : f_rx2 - f_rx1;
      dy = ($signed(f_ry1) >= $signed(f_ry2)) ? f_ry1 - f_ry2 : f_ry2 - f_ry1;
   end

   // Hold the accepted beat in the stage registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_op_ff    <= op_type'(f_op);
         stage_last_ff  <= req_tlast;
         stage_cell1_ff <= {GRID_BITS'(f_gx1), GRID_BITS'(f_gy1)};
         stage_cell2_ff <= {GRID_BITS'(f_gx2), GRID_BITS'(f_gy2)};
         stage_dx_ff    <= dx;
         stage_dy_ff    <= dy;
      end
   end

   assign new_len = {1'b0, stage_dx_ff} + {1'b0, stage_dy_ff};

   // Evaluate the probe returning from the tail of the row
   always_comb begin
      table_full   = (count_ff == CNT_W'(MAX_WIRES));
      probe_done   = (state_ff == ST_SCAN) && probe_tail.valid;
      sum_wide     = {1'b0, sum_ff} + (PATH_W + 1)'(probe_tail.len);
      sum_sat      = sum_wide[PATH_W] ? {PATH_W{1'b1}} : sum_wide[PATH_W-1:0];
      left_dec     = left_ff - 1'b1;
      step_reached = probe_tail.found && (hit_end_tail == load_ff);
      step_out     = !probe_tail.found || step_reached || (left_dec == '0);
      start_empty  = overflow_ff || (count_ff == '0);
      post_fire    = (state_ff == ST_POST) && (!rsp_valid_ff || rsp_tready);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (stage_valid_ff && stage_last_ff) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = start_empty ? ST_POST : ST_SCAN;
         end
         ST_SCAN: begin
            if (probe_done && step_out) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (post_fire) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Handshake and chain controls
   always_comb begin
      req_tready = (state_ff == ST_LOAD) && !(stage_valid_ff && stage_last_ff);
      shift_en   = (state_ff == ST_LOAD) && stage_valid_ff &&
                   (stage_op_ff == OP_WIRE) && !table_full;
      launch     = ((state_ff == ST_START) && !start_empty) ||
                   (probe_done && !step_out);
   end

   // Datapath next values
   always_comb begin
      stage_valid_in = req_fire;
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      driver_in      = driver_ff;
      load_in        = load_ff;
      cur_in         = cur_ff;
      sum_in         = sum_ff;
      left_in        = left_ff;
      res_len_in     = res_len_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_LOAD: begin
            // Store the held record
            if (stage_valid_ff) begin
               case (stage_op_ff)
                  OP_DRIVER: driver_in = stage_cell1_ff;
                  OP_LOAD:   load_in   = stage_cell1_ff;
                  OP_WIRE: begin
                     if (table_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            res_len_in = '0;
            if (overflow_ff) begin
               res_status_in = STATUS_OVERFLOW;
            end else if (count_ff == '0) begin
               res_status_in = STATUS_EXHAUSTED;
            end else begin
               cur_in  = driver_ff;
               sum_in  = '0;
               left_in = count_ff;
            end
         end
         ST_SCAN: begin
            if (probe_done) begin
               sum_in  = sum_sat;
               cur_in  = hit_end_tail;
               left_in = left_dec;
               res_len_in = '0;
               if (!probe_tail.found) begin
                  res_status_in = STATUS_INTERRUPTED;
               end else if (step_reached) begin
                  res_status_in = STATUS_REACHED;
                  res_len_in    = sum_sat;
               end else begin
                  res_status_in = STATUS_EXHAUSTED;
               end
            end
         end
         ST_POST: begin
            // Post the result and empty the net
            if (post_fire) begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
               overflow_in  = 1'b0;
               driver_in    = '0;
               load_in      = '0;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         stage_valid_ff <= 1'b0;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         driver_ff      <= '0;
         load_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stage_valid_ff <= stage_valid_in;
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         driver_ff      <= driver_in;
         load_ff        <= load_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Walk and result payload
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      sum_ff        <= sum_in;
      left_ff       <= left_in;
      res_len_ff    <= res_len_in;
      res_status_ff <= res_status_in;
      if (post_fire) begin
         rsp_len_ff    <= res_len_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // Probe entering the head of the row
   always_comb begin
      probe_head.valid = launch;
      probe_head.found = 1'b0;
      probe_head.len   = '0;
   end

   // The head cell meets the probe in its launch cycle, so it compares against the
   // cell the step starts from, not the one still held from the previous step
   rplw_chain #(
      .MAX_WIRES (MAX_WIRES),
      .CELL_W    (CELL_W),
      .CNT_W     (CNT_W)
   ) u_chain (
      .clock        (clock),
      .reset        (reset),
      .shift_en     (shift_en),
      .cur_cell     (cur_in),
      .new_start    (stage_cell1_ff),
      .new_end      (stage_cell2_ff),
      .new_len      (new_len),
      .probe_head   (probe_head),
      .left_head    (count_ff),
      .probe_tail   (probe_tail),
      .hit_end_tail (hit_end_tail)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PATH_W)'(0), rsp_len_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Checks
   `RPLW_ASSERT_IMPL(a_ready_only_loading, state_ff != ST_LOAD, !req_tready)
   `RPLW_ASSERT_IMPL(a_probe_only_scanning, probe_tail.valid, state_ff == ST_SCAN)
   `RPLW_ASSERT(a_count_in_range, count_ff <= CNT_W'(MAX_WIRES))
   `RPLW_ASSERT_IMPL(a_scan_has_wires, state_ff == ST_SCAN, left_ff != '0)
   `RPLW_ASSERT_IMPL(a_result_from_post, $rose(rsp_valid_ff), $past(state_ff) == ST_POST)

endmodule
